// ===== src/sts_pkg.sv =====
// shared types and constants for the sorted table search block
// no dependencies; imported by sts_table_ram and sorted_table_search
`timescale 1ns / 1ps

package sts_pkg;

   localparam int unsigned DEFAULT_TABLE_DEPTH = 256;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned INDEX_W   = 8;
   localparam int unsigned POS_W     = 8;
   localparam int unsigned COUNT_W   = 9;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 32;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_MODE = 2'd1;

   // request opcodes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // search modes
   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_BINARY = 1'b1;

   typedef struct packed {
      logic                     opcode;
      logic [INDEX_W-1:0]       entry_index;
      logic signed [DATA_W-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_CHECK
   } state_type;

endpackage

// ===== src/sorted_table_search.sv =====
// top level of the sorted table search block: control, registers, result
// depends on sts_pkg and sts_table_ram
`timescale 1ns / 1ps

// usage
//   request channel: drive req_data and raise start; the transaction is taken
//   at a rising edge with start high and busy low. a load transaction writes
//   one table entry (index beyond the table is dropped) and gives no result.
//   a search transaction gives exactly one result on rsp_data, marked by
//   rsp_valid for a single cycle; the receiver cannot hold it off.
//   csr channel: csr_ready is always high, a write lands at the edge with
//   csr_valid high. index 0 is entry_count, index 1 is search_mode; other
//   indexes are ignored. write only while no search is in flight.
// timing
//   a load leaves busy low, so loads can stream every cycle while no search
//   is in flight. a search holds busy while it probes the table: the table
//   ram has one read port with registered read data and each probe's compare
//   picks the next address. binary mode needs up to ceil(log2(count+1))
//   probes (8 for a full 255-entry range, 9 for 256), linear mode up to count.
//   the result strobe comes in the cycle after the last probe, and a new
//   transaction can be taken in that same cycle. count 0 answers without a probe.
// reset
//   synchronous, active high: entry_count 0, binary mode, no result pending.
//   the table itself is not cleared; entries are valid once loaded.

module sorted_table_search #(
   parameter int unsigned TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  sts_pkg::req_type                  req_data,
   // result channel
   output logic                              rsp_valid,
   output sts_pkg::rsp_type                  rsp_data,
   // configuration channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sts_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import sts_pkg::*;

   // table address width, count width, and a signed bound width that holds -1
   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned IW = CW + 1;

   // configuration registers
   logic [COUNT_W-1:0] entry_count_ff;
   logic               search_mode_ff;

   // search control
   state_type              state_ff, state_in;
   logic signed [IW-1:0]   lo_ff, lo_in;
   logic signed [IW-1:0]   hi_ff, hi_in;
   logic [AW-1:0]          probe_ff, probe_in;
   logic signed [DATA_W-1:0] target_ff, target_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;

   // ram ports
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic signed [DATA_W-1:0] rd_data;

   // working values
   logic [CW-1:0]        used_count;
   logic signed [IW-1:0] probe_ext;
   logic signed [IW-1:0] lo_next;
   logic signed [IW-1:0] hi_next;
   logic signed [IW-1:0] hi_start;

   // midpoint of a nonnegative range, as a table address
   function automatic logic [AW-1:0] mid_of(input logic signed [IW-1:0] lo,
                                            input logic signed [IW-1:0] hi);
      logic signed [IW:0] sum;
      sum    = {{1'b0}, lo} + {{1'b0}, hi};
      mid_of = AW'(sum >>> 1);
   endfunction

   // ---------------------------------------------------------------- csr port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         search_mode_ff <= MODE_BINARY;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_SEARCH_MODE: search_mode_ff <= csr_wdata[0];
            default: ;  // unknown register, write dropped
         endcase
      end
   end

   // count saturated to the table depth
   assign used_count = (32'(entry_count_ff) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                           : CW'(entry_count_ff);
   assign hi_start   = $signed({1'b0, used_count}) - IW'(1);
   assign probe_ext  = $signed({{(IW-AW){1'b0}}, probe_ff});

   // ---------------------------------------------------------------- table ram
   sts_table_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.data_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_addr = AW'(req_data.entry_index);

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      probe_ff     <= probe_in;
      target_ff    <= target_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      probe_in     = probe_ff;
      target_in    = target_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = probe_ff;
      lo_next      = lo_ff;
      hi_next      = hi_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.opcode == OP_LOAD) begin
                  // loads past the table end are dropped
                  wr_en = (32'(req_data.entry_index) < TABLE_DEPTH);
               end else begin
                  target_in = req_data.data_value;
                  if (used_count == '0) begin
                     // empty range answers at once
                     rsp_valid_in = 1'b1;
                     rsp_found_in = 1'b0;
                     rsp_pos_in   = '0;
                  end else begin
                     lo_in    = '0;
                     hi_in    = hi_start;
                     rd_addr  = (search_mode_ff == MODE_BINARY) ? mid_of('0, hi_start)
                                                                : '0;
                     rd_en    = 1'b1;
                     probe_in = rd_addr;
                     state_in = ST_CHECK;
                  end
               end
            end
         end

         ST_CHECK: begin
            if (rd_data == target_ff) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_pos_in   = POS_W'(probe_ff);
               state_in     = ST_IDLE;
            end else begin
               // linear mode only ever moves the low bound up by one
               if ((search_mode_ff == MODE_BINARY) && (target_ff < rd_data)) begin
                  hi_next = probe_ext - IW'(1);
               end else begin
                  lo_next = probe_ext + IW'(1);
               end
               lo_in = lo_next;
               hi_in = hi_next;
               if (lo_next > hi_next) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_pos_in   = '0;
                  state_in     = ST_IDLE;
               end else begin
                  rd_addr  = (search_mode_ff == MODE_BINARY) ? mid_of(lo_next, hi_next)
                                                             : AW'(lo_next);
                  rd_en    = 1'b1;
                  probe_in = rd_addr;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data.found    = rsp_found_ff;
   assign rsp_data.position = rsp_pos_ff;

endmodule

// ===== src/sts_table_ram.sv =====
// value table storage: one write port, one read port, registered read data
// depends on sts_pkg for the data width and the default depth
`timescale 1ns / 1ps

module sts_table_ram #(
   parameter int unsigned DEPTH  = sts_pkg::DEFAULT_TABLE_DEPTH,
   parameter int unsigned ADDR_W = 8
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [ADDR_W-1:0]                 wr_addr,
   input  logic signed [sts_pkg::DATA_W-1:0] wr_data,
   input  logic                              rd_en,
   input  logic [ADDR_W-1:0]                 rd_addr,
   output logic signed [sts_pkg::DATA_W-1:0] rd_data
);
   import sts_pkg::*;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
